// ----- rtl/core/pat3d_pkg.sv -----
`default_nettype none
package pat3d_pkg;

  localparam int TRIG_STEPS = 16;
  localparam int ATAN_ENTRIES = 24;
  localparam int STEPS = (TRIG_STEPS < 1) ? 1 :
                         ((TRIG_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : TRIG_STEPS);

  // item path in order: angle reduction, cordic steps, quadrant map, three axes,
  // output register
  localparam int RED_LAT = 3;
  localparam int TRIG_LAT = RED_LAT + STEPS + 1;
  localparam int AXIS_LAT = 2;
  localparam int LAT = TRIG_LAT + 3 * AXIS_LAT + 1;

  localparam logic signed [31:0] DEG_FULL = 32'sd23592960;
  localparam logic signed [31:0] DEG_QUARTER = 32'sd5898240;
  localparam logic [31:0] DEG_TO_RAD_Q32 = 32'd74961321;
  localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;

  typedef enum logic [1:0] {
    ACT_SCALE  = 2'd0,
    ACT_MOVE   = 2'd1,
    ACT_ROTATE = 2'd2,
    ACT_PASS   = 2'd3
  } action_t;

  typedef struct packed {
    logic [1:0] action;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic signed [31:0] c;
  } item_t;

  typedef struct packed {
    logic signed [33:0] c;
    logic signed [33:0] s;
  } trig_t;

  function automatic logic signed [33:0] atan_q30(input int i);
    logic signed [33:0] r;
    case (i)
      0: r = 34'sd843314856;
      1: r = 34'sd497837829;
      2: r = 34'sd263043836;
      3: r = 34'sd133525158;
      4: r = 34'sd67021686;
      5: r = 34'sd33543515;
      6: r = 34'sd16775850;
      7: r = 34'sd8388437;
      8: r = 34'sd4194282;
      9: r = 34'sd2097149;
      10: r = 34'sd1048575;
      11: r = 34'sd524287;
      12: r = 34'sd262143;
      13: r = 34'sd131071;
      14: r = 34'sd65535;
      15: r = 34'sd32767;
      16: r = 34'sd16383;
      17: r = 34'sd8191;
      18: r = 34'sd4095;
      19: r = 34'sd2047;
      20: r = 34'sd1023;
      21: r = 34'sd511;
      22: r = 34'sd255;
      default: r = 34'sd127;
    endcase
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [66:0] v);
    logic signed [31:0] r;
    if (v > 67'sd2147483647) r = 32'sh7fffffff;
    else if (v < -67'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/pat3d_trig.sv -----
`default_nettype none
// angle in degrees to (cos, sin) in Q4.30, one cordic step per stage
module pat3d_trig (
  input  wire logic clk,
  input  wire logic en,
  input  wire logic signed [31:0] deg,
  output pat3d_pkg::trig_t trig
);
  import pat3d_pkg::*;

  // stage 1: turn estimate for the remainder mod 360 (range fold by compare/subtract in stage 2)
  // deg range ~ +-91 full turns; a q-estimate via reciprocal then correct
  logic signed [31:0] d1;
  logic signed [7:0] qt1;
  logic signed [63:0] prod0;
  // 2^32/23592960 = 182.04; estimate turns = (deg*182) >> 32; use floor estimate
  always_comb prod0 = 64'(deg) * 64'sd182;
  always_ff @(posedge clk) begin
    if (en) begin
      d1 <= deg;
      qt1 <= prod0[39:32];
    end
  end

  // stage 2: r = d - t*FULL, correct into [0, FULL)
  logic signed [39:0] r2raw;
  logic signed [39:0] r2;
  always_comb begin
    r2raw = 40'(d1) - 40'(qt1) * 40'(DEG_FULL);
    r2 = r2raw;
    if (r2 < 0) r2 = r2 + 40'(DEG_FULL);
    if (r2 < 0) r2 = r2 + 40'(DEG_FULL);
    if (r2 >= 40'(DEG_FULL)) r2 = r2 - 40'(DEG_FULL);
    if (r2 >= 40'(DEG_FULL)) r2 = r2 - 40'(DEG_FULL);
  end
  logic [1:0] q2;
  logic [22:0] f2;
  always_comb begin
    q2 = 2'd0;
    f2 = 23'(r2);
    if (r2 >= 40'(3 * DEG_QUARTER)) begin
      q2 = 2'd3; f2 = 23'(r2 - 40'(3 * DEG_QUARTER));
    end else if (r2 >= 40'(2 * DEG_QUARTER)) begin
      q2 = 2'd2; f2 = 23'(r2 - 40'(2 * DEG_QUARTER));
    end else if (r2 >= 40'(DEG_QUARTER)) begin
      q2 = 2'd1; f2 = 23'(r2 - 40'(DEG_QUARTER));
    end
  end
  logic [1:0] q3;
  logic [22:0] f3;
  always_ff @(posedge clk) begin
    if (en) begin
      q3 <= q2;
      f3 <= f2;
    end
  end

  // stage 3: radians in Q4.30
  logic [54:0] rad_prod;
  always_comb rad_prod = 55'(f3) * 55'(DEG_TO_RAD_Q32);
  logic signed [33:0] z0;
  logic [1:0] q0;
  always_ff @(posedge clk) begin
    if (en) begin
      z0 <= 34'($signed({1'b0, rad_prod[54:18]}));
      q0 <= q3;
    end
  end

  // cordic stages
  logic signed [33:0] cx [0:STEPS];
  logic signed [33:0] cy [0:STEPS];
  logic signed [33:0] cz [0:STEPS];
  logic [1:0] cq [0:STEPS];
  assign cx[0] = CORDIC_GAIN_Q30;
  assign cy[0] = '0;
  assign cz[0] = z0;
  assign cq[0] = q0;

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) begin
        if (cz[i] >= 0) begin
          cx[i+1] <= cx[i] - (cy[i] >>> i);
          cy[i+1] <= cy[i] + (cx[i] >>> i);
          cz[i+1] <= cz[i] - atan_q30(i);
        end else begin
          cx[i+1] <= cx[i] + (cy[i] >>> i);
          cy[i+1] <= cy[i] - (cx[i] >>> i);
          cz[i+1] <= cz[i] + atan_q30(i);
        end
        cq[i+1] <= cq[i];
      end
    end
  end

  // quadrant map
  always_ff @(posedge clk) begin
    if (en) begin
      case (cq[STEPS])
        2'd0: begin trig.c <= cx[STEPS]; trig.s <= cy[STEPS]; end
        2'd1: begin trig.c <= -cy[STEPS]; trig.s <= cx[STEPS]; end
        2'd2: begin trig.c <= -cx[STEPS]; trig.s <= -cy[STEPS]; end
        default: begin trig.c <= cy[STEPS]; trig.s <= -cx[STEPS]; end
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- rtl/core/pat3d_turn.sv -----
`default_nettype none
// one axis rotation: products registered, then sum, round and saturate
module pat3d_turn (
  input  wire logic clk,
  input  wire logic en,
  input  wire logic signed [31:0] u,
  input  wire logic signed [31:0] v,
  input  wire pat3d_pkg::trig_t trig,
  output logic signed [31:0] u_out,
  output logic signed [31:0] v_out
);
  import pat3d_pkg::*;

  logic signed [65:0] uc, vs, vc, us;
  always_ff @(posedge clk) begin
    if (en) begin
      uc <= 66'(u) * 66'(trig.c);
      vs <= 66'(v) * 66'(trig.s);
      vc <= 66'(v) * 66'(trig.c);
      us <= 66'(u) * 66'(trig.s);
    end
  end

  logic signed [66:0] su, sv;
  always_comb begin
    su = (67'(uc) + 67'(vs) + 67'sd536870912) >>> 30;
    sv = (67'(vc) - 67'(us) + 67'sd536870912) >>> 30;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      u_out <= sat32(su);
      v_out <= sat32(sv);
    end
  end
endmodule
`default_nettype wire

// ----- rtl/core/point_affine_transform_3d_core.sv -----
`default_nettype none
// channel | dir | tdata fields (low bit first)
// s_axis  | in  | action[1:0] in_x in_y in_z operand_a operand_b operand_c, 200 bits
// m_axis  | out | out_x out_y out_z, 96 bits
//
// one word per cycle while the output is not stalled; a word passes through
// angle fold, cordic, quadrant map, three axes and output register
// three cordic pipes run in parallel, one per angle, and the axes follow in order
// rst clears only the stage valid bits; no word is taken while rst is high
// the whole pipe advances when the output register is empty or being taken;
// a stall freezes every stage, so nothing is lost or repeated
module point_affine_transform_3d_core (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic s_axis_tvalid,
  output logic s_axis_tready,
  input  wire logic [199:0] s_axis_tdata, // action, in_x, in_y, in_z, operand_a..c
  output logic m_axis_tvalid,
  input  wire logic m_axis_tready,
  output logic [95:0] m_axis_tdata        // out_x, out_y, out_z
);
  import pat3d_pkg::*;

  logic en;
  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en && !rst;

  item_t din;
  always_comb begin
    din.action = s_axis_tdata[1:0];
    din.x = s_axis_tdata[33:2];
    din.y = s_axis_tdata[65:34];
    din.z = s_axis_tdata[97:66];
    din.a = s_axis_tdata[129:98];
    din.b = s_axis_tdata[161:130];
    din.c = s_axis_tdata[193:162];
  end

  // valid bits along the pipe
  logic [LAT-1:0] vld;
  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[LAT-2:0], s_axis_tvalid};
  end
  assign m_axis_tvalid = vld[LAT-1];

  // item delay line, aligned to trig output
  item_t dly [0:TRIG_LAT];
  assign dly[0] = din;
  for (genvar i = 0; i < TRIG_LAT; i++) begin : g_dly
    always_ff @(posedge clk) begin
      if (en) dly[i+1] <= dly[i];
    end
  end
  item_t it;
  assign it = dly[TRIG_LAT];

  trig_t ta, tb, tc;
  pat3d_trig u_ta (.clk(clk), .en(en), .deg(din.a), .trig(ta));
  pat3d_trig u_tb (.clk(clk), .en(en), .deg(din.b), .trig(tb));
  pat3d_trig u_tc (.clk(clk), .en(en), .deg(din.c), .trig(tc));

  // trig delays for later axes
  trig_t tb1 [0:AXIS_LAT];
  trig_t tc1 [0:2*AXIS_LAT];
  assign tb1[0] = tb;
  assign tc1[0] = tc;
  for (genvar i = 0; i < AXIS_LAT; i++) begin : g_tb
    always_ff @(posedge clk) if (en) tb1[i+1] <= tb1[i];
  end
  for (genvar i = 0; i < 2*AXIS_LAT; i++) begin : g_tc
    always_ff @(posedge clk) if (en) tc1[i+1] <= tc1[i];
  end

  // scale / move result computed where the rotation chain starts, carried along
  logic signed [31:0] sm_x, sm_y, sm_z;
  logic signed [63:0] px, py, pz;
  always_comb begin
    px = 64'(it.x) * 64'(it.a);
    py = 64'(it.y) * 64'(it.b);
    pz = 64'(it.z) * 64'(it.c);
  end
  logic signed [63:0] rpx, rpy, rpz;
  logic [1:0] act1;
  logic signed [31:0] ix1, iy1, iz1, ia1, ib1, ic1;
  always_ff @(posedge clk) begin
    if (en) begin
      rpx <= px; rpy <= py; rpz <= pz;
      act1 <= it.action;
      ix1 <= it.x; iy1 <= it.y; iz1 <= it.z;
      ia1 <= it.a; ib1 <= it.b; ic1 <= it.c;
    end
  end
  always_comb begin
    case (act1)
      ACT_SCALE: begin
        sm_x = sat32((67'(rpx) + 67'sd32768) >>> 16);
        sm_y = sat32((67'(rpy) + 67'sd32768) >>> 16);
        sm_z = sat32((67'(rpz) + 67'sd32768) >>> 16);
      end
      ACT_MOVE: begin
        sm_x = sat32(67'(ix1) + 67'(ia1));
        sm_y = sat32(67'(iy1) + 67'(ib1));
        sm_z = sat32(67'(iz1) + 67'(ic1));
      end
      default: begin
        sm_x = ix1; sm_y = iy1; sm_z = iz1;
      end
    endcase
  end
  // carry the simple result and action to the end (3*AXIS_LAT - 1 more stages)
  localparam int CARRY = 3 * AXIS_LAT - 1;
  logic [97:0] cr [0:CARRY];
  assign cr[0] = {act1, sm_x, sm_y, sm_z};
  for (genvar i = 0; i < CARRY; i++) begin : g_cr
    always_ff @(posedge clk) if (en) cr[i+1] <= cr[i];
  end

  // rotation chain: x axis turns (y,z), y axis (x,z), z axis (x,y)
  logic signed [31:0] y1, z1, x2, z2, x3, y3;
  logic signed [31:0] xd [0:AXIS_LAT];
  logic signed [31:0] yd [0:AXIS_LAT];
  logic signed [31:0] zd [0:AXIS_LAT];
  pat3d_turn u_rx (.clk(clk), .en(en), .u(it.y), .v(it.z), .trig(ta), .u_out(y1), .v_out(z1));
  assign xd[0] = it.x;
  for (genvar i = 0; i < AXIS_LAT; i++) begin : g_xd
    always_ff @(posedge clk) if (en) xd[i+1] <= xd[i];
  end
  pat3d_turn u_ry (.clk(clk), .en(en), .u(xd[AXIS_LAT]), .v(z1), .trig(tb1[AXIS_LAT]),
                   .u_out(x2), .v_out(z2));
  assign yd[0] = y1;
  for (genvar i = 0; i < AXIS_LAT; i++) begin : g_yd
    always_ff @(posedge clk) if (en) yd[i+1] <= yd[i];
  end
  pat3d_turn u_rz (.clk(clk), .en(en), .u(x2), .v(yd[AXIS_LAT]), .trig(tc1[2*AXIS_LAT]),
                   .u_out(x3), .v_out(y3));
  assign zd[0] = z2;
  for (genvar i = 0; i < AXIS_LAT; i++) begin : g_zd
    always_ff @(posedge clk) if (en) zd[i+1] <= zd[i];
  end

  // output register
  always_ff @(posedge clk) begin
    if (en) begin
      if (cr[CARRY][97:96] == ACT_ROTATE) m_axis_tdata <= {zd[AXIS_LAT], y3, x3};
      else m_axis_tdata <= {cr[CARRY][31:0], cr[CARRY][63:32], cr[CARRY][95:64]};
    end
  end
endmodule
`default_nettype wire
